>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define ITA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset too
`define ITA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ita_pkg.sv
package ita_pkg;

    typedef logic [5:0] t_radix;
    typedef logic [5:0] t_digit;
    typedef logic [6:0] t_char;

    localparam int CHUNK_BITS = 8;

    localparam t_radix RADIX_MIN   = 6'd2;
    localparam t_radix RADIX_MAX   = 6'd36;
    localparam t_radix RADIX_RESET = 6'd10;

    localparam t_char  ASCII_DIGIT_BASE  = 7'd48;
    localparam t_char  ASCII_LETTER_BASE = 7'd55;
    localparam t_digit DECIMAL_LIMIT     = 6'd10;

    function automatic t_char digit_to_ascii(input t_digit d);
        t_char ext;
        ext = {1'b0, d};
        if (d < DECIMAL_LIMIT) begin
            return ext + ASCII_DIGIT_BASE;
        end
        return ext + ASCII_LETTER_BASE;
    endfunction

    function automatic t_radix clamp_radix(input t_radix r);
        if (r < RADIX_MIN) begin
            return RADIX_MIN;
        end
        if (r > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return r;
    endfunction

endpackage

>>> rtl/ita_value_if.sv
interface ita_value_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/ita_digit_if.sv
interface ita_digit_if;
    logic       valid;
    logic       ready;
    logic [6:0] digit_char;
    logic       last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

>>> rtl/integer_to_radix_ascii_core.sv
// Converts an unsigned integer to ASCII digits ('0'-'9', 'A'-'Z') in the radix
// held in the configuration register (2 to 36, values outside are clamped; reset
// value 10), most significant digit first, one digit per output beat, with
// last_digit set on the final one. Zero gives the single digit '0'; a value that
// needs more than MAX_DIGITS digits keeps only its MAX_DIGITS lowest digits.
// Each digit comes from one pass of a shared divider that consumes 8 dividend
// bits per cycle, working from the top of the value down; the digits go into a
// digit memory and are read back from it one at a time, each read registered
// before its beat is offered, and each beat is held through output stalls. The
// value is accepted in the idle state, and the input is not ready until the
// last digit beat has been taken.
// Write the radix only while the block is idle.
`include "assert_macros.svh"

module integer_to_radix_ascii_core #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  ita_pkg::t_radix   i_cfg_wr_data,
    ita_value_if.sink         i_value_ch,
    ita_digit_if.source       o_digit_ch
);
    import ita_pkg::*;

    localparam int CHUNKS = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int QW     = CHUNKS * CHUNK_BITS;
    localparam int KW     = $clog2(CHUNKS + 1);
    localparam int AW     = $clog2(MAX_DIGITS);
    localparam int CW     = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]    r_state, n_state;
    t_radix        r_radix;
    t_radix        r_base, n_base;
    logic [QW-1:0] r_quo, n_quo;
    t_digit        r_rem, n_rem;
    logic [KW-1:0] r_chunk, n_chunk;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_idx, n_idx;

    t_digit                  step_rem;
    logic [CHUNK_BITS-1:0]   step_quo;
    logic [QW+CHUNK_BITS-1:0] quo_shift;
    logic [CW-1:0]           cnt_inc;
    logic                    last_chunk;
    logic                    wr_en;
    logic                    rd_en;
    t_digit                  rd_data;
    logic                    in_beat;
    logic                    out_beat;

    ita_div_step u_div_step (
        .i_base (r_base),
        .i_rem  (r_rem),
        .i_bits (r_quo[QW-1 -: CHUNK_BITS]),
        .o_rem  (step_rem),
        .o_quo  (step_quo)
    );

    ita_digit_store #(
        .DEPTH (MAX_DIGITS),
        .AW    (AW)
    ) u_digit_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (step_rem),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    assign quo_shift  = {r_quo, step_quo};
    assign cnt_inc    = r_cnt + 1'b1;
    assign last_chunk = (r_chunk == KW'(CHUNKS - 1));
    assign wr_en      = (r_state == S_DIV) && last_chunk;
    assign rd_en      = (r_state == S_READ);

    assign i_value_ch.ready      = (r_state == S_IDLE);
    assign o_digit_ch.valid      = (r_state == S_OUT);
    assign o_digit_ch.digit_char = digit_to_ascii(rd_data);
    assign o_digit_ch.last_digit = (r_idx == '0);

    assign in_beat  = i_value_ch.valid && i_value_ch.ready;
    assign out_beat = o_digit_ch.valid && o_digit_ch.ready;

    always_comb begin
        n_state = r_state;
        n_base  = r_base;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_chunk = r_chunk;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_value_ch.valid) begin
                    n_state = S_DIV;
                    n_base  = clamp_radix(r_radix);
                    n_quo   = QW'(i_value_ch.value);
                    n_rem   = '0;
                    n_chunk = '0;
                    n_cnt   = '0;
                end
            end
            S_DIV: begin
                n_quo = quo_shift[QW-1:0];
                n_rem = step_rem;
                if (last_chunk) begin
                    n_cnt   = cnt_inc;
                    n_rem   = '0;
                    n_chunk = '0;
                    if (quo_shift[QW-1:0] == '0 || cnt_inc == CW'(MAX_DIGITS)) begin
                        n_idx   = r_cnt[AW-1:0];
                        n_state = S_READ;
                    end
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_digit_ch.ready) begin
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_radix <= RADIX_RESET;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_wr_en) begin
                r_radix <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_chunk <= n_chunk;
        r_idx   <= n_idx;
    end

    `ITA_ASSERT(a_no_overlap, i_clk, i_rst_n, !(i_value_ch.ready && o_digit_ch.valid), "input ready while a digit is pending")
    `ITA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, in_beat |=> !i_value_ch.ready, "input ready right after accepting a value")
    `ITA_ASSERT(a_mid_string_busy, i_clk, i_rst_n, (out_beat && !o_digit_ch.last_digit) |=> (!i_value_ch.ready && !o_digit_ch.valid), "digit string broken before last digit")
    `ITA_ASSERT(a_idle_after_last, i_clk, i_rst_n, (out_beat && o_digit_ch.last_digit) |=> i_value_ch.ready, "not idle after last digit")
    `ITA_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(MAX_DIGITS), "digit count beyond store depth")

endmodule

>>> rtl/ita_div_step.sv
module ita_div_step (
    input  ita_pkg::t_radix                 i_base,
    input  ita_pkg::t_digit                 i_rem,
    input  logic [ita_pkg::CHUNK_BITS-1:0]  i_bits,
    output ita_pkg::t_digit                 o_rem,
    output logic [ita_pkg::CHUNK_BITS-1:0]  o_quo
);
    import ita_pkg::*;

    // restoring division, one quotient bit per step, msb first
    always_comb begin
        logic [6:0] part;
        t_digit     rem;
        rem   = i_rem;
        o_quo = '0;
        for (int b = CHUNK_BITS - 1; b >= 0; b--) begin
            part = {rem, i_bits[b]};
            if (part >= {1'b0, i_base}) begin
                part     = part - {1'b0, i_base};
                o_quo[b] = 1'b1;
            end
            rem = part[5:0];
        end
        o_rem = rem;
    end

endmodule

>>> rtl/ita_digit_store.sv
module ita_digit_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  ita_pkg::t_digit i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output ita_pkg::t_digit o_rd_data
);
    import ita_pkg::*;

    t_digit r_mem [DEPTH];
    t_digit r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> tb/sv/ita_digit_checker.sv
module ita_digit_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  ita_pkg::t_radix i_cfg_wr_data,
    input  logic            i_value_valid,
    input  logic            i_value_ready,
    input  logic [31:0]     i_value,
    input  logic            i_digit_valid,
    input  logic            i_digit_ready,
    input  logic [6:0]      i_digit_char,
    input  logic            i_last_digit,
    output int              o_mismatch_count,
    output int              o_digits_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ita_pkg::*;

    localparam int DIGIT_LIMIT = 32;

    typedef struct packed {
        t_char digit_char;
        logic  last_digit;
    } t_digit_beat;

    t_digit_beat digits_due[$];
    t_radix      radix_reg;
    int          mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] digit check: %s", $time, what);
    endtask

    // divide out the value, then queue the digits most significant first
    function automatic void predict_digits(input logic [31:0] value, input t_radix radix_set);
        t_radix      base;
        t_digit      low_first[$];
        logic [31:0] rest;
        t_char       code;
        t_digit_beat beat;
        base = radix_set;
        if (base < 6'd2) begin
            base = 6'd2;
        end else if (base > 6'd36) begin
            base = 6'd36;
        end
        rest = value;
        do begin
            low_first.push_back(t_digit'(rest % base));
            rest = rest / base;
        end while (rest != 0 && low_first.size() < DIGIT_LIMIT);
        for (int k = low_first.size() - 1; k >= 0; k--) begin
            code = {1'b0, low_first[k]};
            if (low_first[k] < DECIMAL_LIMIT) begin
                code = code + ASCII_DIGIT_BASE;
            end else begin
                code = code + ASCII_LETTER_BASE;
            end
            beat.digit_char = code;
            beat.last_digit = (k == 0);
            digits_due.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_digit_beat due;
        if (!i_rst_n) begin
            radix_reg = RADIX_RESET;
            digits_due.delete();
        end else begin
            if (i_digit_valid && i_digit_ready) begin
                if (digits_due.size() == 0) begin
                    report_mismatch($sformatf("beat char %0d with nothing expected",
                                              i_digit_char));
                end else begin
                    due = digits_due.pop_front();
                    if (i_digit_char !== due.digit_char) begin
                        report_mismatch($sformatf("digit_char %0d, expected %0d",
                                                  i_digit_char, due.digit_char));
                    end
                    if (i_last_digit !== due.last_digit) begin
                        report_mismatch($sformatf("last_digit %0b, expected %0b",
                                                  i_last_digit, due.last_digit));
                    end
                end
            end
            if (i_value_valid && i_value_ready) begin
                predict_digits(i_value, radix_reg);
            end
            if (i_cfg_wr_en) begin
                radix_reg = i_cfg_wr_data;
            end
        end
        o_digits_pending <= digits_due.size();
    end
endmodule

>>> tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ita_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 160;
    localparam int RADIX_EVERY  = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 250;

    logic   clk;
    logic   rst_n;
    logic   cfg_wr_en;
    t_radix cfg_wr_data;
    int     tx_idle_pct;
    int     rx_idle_pct;
    bit     hold_now;
    int     mismatch_count;
    int     digits_pending;

    ita_value_if #(.VALUE_WIDTH(32)) value_ch ();
    ita_digit_if                     digit_ch ();

    integer_to_radix_ascii_core #(
        .VALUE_WIDTH(32),
        .MAX_DIGITS (32)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_value_ch   (value_ch),
        .o_digit_ch   (digit_ch)
    );

    ita_digit_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_value_valid   (value_ch.valid),
        .i_value_ready   (value_ch.ready),
        .i_value         (value_ch.value),
        .i_digit_valid   (digit_ch.valid),
        .i_digit_ready   (digit_ch.ready),
        .i_digit_char    (digit_ch.digit_char),
        .i_last_digit    (digit_ch.last_digit),
        .o_mismatch_count(mismatch_count),
        .o_digits_pending(digits_pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // digit sink, with one long hold-off when asked
    initial begin : digit_sink
        bit hold_done;
        hold_done = 1'b0;
        digit_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_now && !hold_done) begin
                hold_done = 1'b1;
                digit_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            digit_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic wait_idle();
        do @(posedge clk); while (digits_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_radix(input t_radix radix_val);
        value_ch.valid <= 1'b0;
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= radix_val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_value(input logic [31:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            value_ch.valid <= 1'b0;
            value_ch.value <= $urandom;
            @(posedge clk);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= value;
        do @(posedge clk); while (!value_ch.ready);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'd1 << $urandom_range(31);
            1: return ~(32'd1 << $urandom_range(31));
            2: return $urandom_range(255);
            3: return $urandom_range(40);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_radix pick_radix();
        case ($urandom_range(4))
            0: return 6'd2;
            1: return 6'd36;
            2: return t_radix'($urandom_range(63));
            default: return t_radix'($urandom_range(2, 36));
        endcase
    endfunction

    initial begin : stimulus
        int tx_pct [3];
        int rx_pct [3];
        tx_pct = '{30, 48, 0};
        rx_pct = '{48, 30, 0};
        tx_idle_pct = tx_pct[0];
        rx_idle_pct = rx_pct[0];
        hold_now = 1'b0;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= RADIX_RESET;
        value_ch.valid <= 1'b0;
        value_ch.value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // decimal at reset radix
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1234567890);
        write_radix(6'd36);
        send_value(32'd35);
        send_value(32'd36);
        send_value(32'hFFFF_FFFF);
        send_value(32'd0);
        write_radix(6'd2);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1);
        send_value(32'd0);
        // out of range radix clamps
        write_radix(6'd0);
        send_value(32'd5);
        write_radix(6'd1);
        send_value(32'd6);
        write_radix(6'd37);
        send_value(32'd1295);
        write_radix(6'd63);
        send_value(32'hFFFF_FFFF);
        write_radix(6'd16);
        send_value(32'hDEAD_BEEF);
        send_value(32'h0000_000A);

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = tx_pct[ph];
            rx_idle_pct = rx_pct[ph];
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % RADIX_EVERY == 0) begin
                    write_radix(pick_radix());
                    if (ph == 2 && i == 0) begin
                        hold_now = 1'b1;
                    end
                end
                send_value(pick_value());
            end
        end
        value_ch.valid <= 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
